### hw/rtl/kbsd_pkg.sv
// ----------------------------------------------------------------------------
// kbsd_pkg
// shared types, constants and command codes of the k-best segmentation block
// ----------------------------------------------------------------------------
package kbsd_pkg;

  localparam int unsigned MaxBlocks = 64;
  localparam int unsigned MaxKeep   = 16;
  localparam int unsigned BlkW      = $clog2(MaxBlocks);
  localparam int unsigned RankW     = $clog2(MaxKeep);
  localparam int unsigned CntW      = $clog2(MaxKeep + 1);
  localparam int unsigned GrpW      = 7;
  localparam int unsigned LenW      = 40;
  localparam int unsigned ScoreW    = 32;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 40;
  localparam int unsigned InDataW   = 56;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned TraceLimit = 64;

  localparam logic [LenW-1:0] LenMax = {LenW{1'b1}};

  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdSolve = 2'd1;
  localparam logic [1:0] CmdTrace = 2'd2;

  localparam logic [CfgIdxW-1:0] RegOverhead = 3'd0;
  localparam logic [CfgIdxW-1:0] RegBound    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegBoundEn  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegGroups   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeep     = 3'd4;
  localparam logic [CfgIdxW-1:0] RegBlocks   = 3'd5;

  // one list entry as it travels along the cell chain
  typedef struct packed {
    logic             vld;
    logic [LenW-1:0]  len;
    logic [GrpW-1:0]  grp;
    logic [BlkW-1:0]  start;
    logic [RankW-1:0] back;
  } entry_t;

  // candidate offered to every cell in one cycle
  typedef struct packed {
    logic             vld;
    logic [LenW-1:0]  len;
    logic [GrpW-1:0]  grp;
    logic [BlkW-1:0]  start;
    logic [RankW-1:0] back;
  } cand_t;

endpackage

### hw/rtl/kbsd_cell.sv
// ----------------------------------------------------------------------------
// kbsd_cell
// one slot of the sorted insertion chain
// ----------------------------------------------------------------------------
module kbsd_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clear_i,
  input  logic            load_i,
  input  logic            active_i,
  input  kbsd_pkg::cand_t  cand_i,
  input  kbsd_pkg::entry_t left_i,
  input  logic            left_ins_i,
  output logic            ins_o,
  output kbsd_pkg::entry_t entry_o
);
  import kbsd_pkg::*;

  entry_t ent_q, ent_d;
  logic   here;

  // candidate goes here when this slot is empty or holds a longer entry
  assign here  = cand_i.vld & active_i & (~ent_q.vld | (ent_q.len > cand_i.len));
  assign ins_o = here | left_ins_i;

  always_comb begin
    ent_d = ent_q;
    if (clear_i) begin
      ent_d = '0;
    end else if (load_i && active_i) begin
      if (left_ins_i) begin
        ent_d = left_i;
      end else if (here) begin
        ent_d = '{vld: 1'b1, len: cand_i.len, grp: cand_i.grp,
                  start: cand_i.start, back: cand_i.back};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign entry_o = ent_q;
endmodule

### hw/rtl/kbsd_chain.sv
// ----------------------------------------------------------------------------
// kbsd_chain
// row of cells holding the sorted list of the prefix being solved
// ----------------------------------------------------------------------------
module kbsd_chain (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      clear_i,
  input  logic                      load_i,
  input  logic [kbsd_pkg::CntW-1:0] keep_i,
  input  kbsd_pkg::cand_t            cand_i,
  output kbsd_pkg::entry_t           list_o [kbsd_pkg::MaxKeep]
);
  import kbsd_pkg::*;

  logic   ins  [MaxKeep+1];
  entry_t ents [MaxKeep+1];

  assign ins[0]  = 1'b0;
  assign ents[0] = '0;

  for (genvar g = 0; g < MaxKeep; g++) begin : g_cell
    logic act;
    assign act = (CntW'(g) < keep_i);
    kbsd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .clear_i    (clear_i),
      .load_i     (load_i),
      .active_i   (act),
      .cand_i     (cand_i),
      .left_i     (ents[g]),
      .left_ins_i (ins[g]),
      .ins_o      (ins[g+1]),
      .entry_o    (ents[g+1])
    );
    assign list_o[g] = ents[g+1];
  end
endmodule

### hw/rtl/k_best_segmentation_dp_top.sv
// ----------------------------------------------------------------------------
// k_best_segmentation_dp_top
// k-best optimal segmentation of a row of blocks by dynamic programming
// ----------------------------------------------------------------------------
// A load request writes one segment score in the cycle it is accepted, so loads
// can follow back to back. A solve request builds, for each prefix end i, a
// sorted list of up to keep_count best partitions in a chain of MaxKeep
// insertion cells: each candidate (group start j, prior rank r) passes through
// score and prior entry read, wait and insert, a start whose prior list is
// empty passes through the read and a skip step, and each row adds a clear
// step plus one copy step per list entry (at least one). Results of a solve
// are the final list best first, each read and then emitted; a trace first
// checks its rank and then follows back pointers, reading, waiting on and
// emitting each group. Output stalls hold the emit and trace steps. Lists live
// in a flat memory indexed by prefix*MaxKeep+rank; list lengths per prefix
// sit in a small memory with a valid bit per prefix cleared at reset, so no
// clearing pass is needed.
module k_best_segmentation_dp_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: cmd[1:0], first_block[7:2], last_block[13:8],
  // segment_score[45:14], rank_wanted[49:46], zero fill
  input  logic [kbsd_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: rank[3:0], description_length[43:4], group_count[50:44],
  // group_start[56:51], group_number[62:57], zero fill
  output logic [kbsd_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            cfg_we_i,
  input  logic [kbsd_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [kbsd_pkg::CfgDataW-1:0]   cfg_data_i
);
  import kbsd_pkg::*;

  localparam int unsigned AdrW = BlkW + RankW;

  // states
  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRow   = 4'd1;
  localparam logic [3:0] StSeg   = 4'd2;
  localparam logic [3:0] StRd    = 4'd3;
  localparam logic [3:0] StIns   = 4'd4;
  localparam logic [3:0] StCopy  = 4'd5;
  localparam logic [3:0] StEmitR = 4'd6;
  localparam logic [3:0] StEmit  = 4'd7;
  localparam logic [3:0] StTrR   = 4'd8;
  localparam logic [3:0] StTr    = 4'd9;
  localparam logic [3:0] StOut   = 4'd10;
  localparam logic [3:0] StTrC   = 4'd11;
  localparam logic [3:0] StSkip  = 4'd12;

  // configuration registers
  logic [ScoreW-1:0] ovh_q;
  logic [LenW-1:0]   bound_q;
  logic              ben_q;
  logic [GrpW-1:0]   gall_q;
  logic [4:0]        keep_q;
  logic [6:0]        blk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovh_q <= '0; bound_q <= '0; ben_q <= 1'b0;
      gall_q <= 7'd64; keep_q <= 5'd16; blk_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegOverhead: ovh_q   <= cfg_data_i[ScoreW-1:0];
        RegBound:    bound_q <= cfg_data_i[LenW-1:0];
        RegBoundEn:  ben_q   <= cfg_data_i[0];
        RegGroups:   gall_q  <= cfg_data_i[GrpW-1:0];
        RegKeep:     keep_q  <= cfg_data_i[4:0];
        RegBlocks:   blk_q   <= cfg_data_i[6:0];
        default: ;
      endcase
    end
  end

  // effective limits
  logic [BlkW-1:0] fin;
  logic [CntW-1:0] keep;
  assign fin  = (blk_q == 7'd0) ? '0 :
                (blk_q > 7'(MaxBlocks)) ? BlkW'(MaxBlocks - 1) : BlkW'(blk_q - 7'd1);
  assign keep = (keep_q == 5'd0) ? CntW'(1) :
                (keep_q > 5'(MaxKeep)) ? CntW'(MaxKeep) : CntW'(keep_q);

  // input fields
  logic [1:0]        in_cmd;
  logic [BlkW-1:0]   in_first, in_last;
  logic [ScoreW-1:0] in_score;
  logic [RankW-1:0]  in_rank;
  assign in_cmd   = s_axis_tdata[1:0];
  assign in_first = s_axis_tdata[7:2];
  assign in_last  = s_axis_tdata[13:8];
  assign in_score = s_axis_tdata[45:14];
  assign in_rank  = s_axis_tdata[49:46];

  // memories
  logic [ScoreW-1:0] seg_mem [MaxBlocks*MaxBlocks];
  logic [LenW-1:0]   len_mem [MaxBlocks*MaxKeep];
  logic [GrpW-1:0]   grp_mem [MaxBlocks*MaxKeep];
  logic [BlkW-1:0]   sta_mem [MaxBlocks*MaxKeep];
  logic [RankW-1:0]  bck_mem [MaxBlocks*MaxKeep];
  // list length per prefix, a valid bit makes unwritten prefixes read as zero
  logic [CntW-1:0]      cnt_mem [MaxBlocks];
  logic [MaxBlocks-1:0] cnt_vld_q;

  logic [3:0]        st_q;
  logic [BlkW-1:0]   i_q, j_q;
  logic [CntW-1:0]   t_q;
  logic [CntW-1:0]   k_q;
  logic [ScoreW-1:0] seg_rd_q;
  logic [LenW-1:0]   len_rd_q;
  logic [GrpW-1:0]   grp_rd_q;
  logic [BlkW-1:0]   sta_rd_q;
  logic [RankW-1:0]  bck_rd_q;
  logic [CntW-1:0]   cnt_rd_q;
  logic [LenW-1:0]   tr_len_q;
  logic [GrpW-1:0]   tr_tot_q;
  logic [RankW-1:0]  tr_rank_q;
  logic [GrpW-1:0]   idx_q;
  logic [BlkW-1:0]   tj_q;
  logic [RankW-1:0]  tk_q;
  logic              out_vld_q, out_last_q;
  logic [OutDataW-1:0] out_data_q;

  // memory port control
  logic            seg_we, seg_re, lst_we, lst_re, cnt_we, cnt_re;
  logic [11:0]     seg_wa, seg_ra;
  logic [AdrW-1:0] lst_wa, lst_ra;
  logic [BlkW-1:0] cnt_wa, cnt_ra;
  entry_t          cp_ent;

  always_ff @(posedge clk_i) begin
    if (seg_we) seg_mem[seg_wa] <= in_score;
    if (seg_re) seg_rd_q <= seg_mem[seg_ra];
    if (lst_we) begin
      len_mem[lst_wa] <= cp_ent.len;
      grp_mem[lst_wa] <= cp_ent.grp;
      sta_mem[lst_wa] <= cp_ent.start;
      bck_mem[lst_wa] <= cp_ent.back;
    end
    if (lst_re) begin
      len_rd_q <= len_mem[lst_ra];
      grp_rd_q <= grp_mem[lst_ra];
      sta_rd_q <= sta_mem[lst_ra];
      bck_rd_q <= bck_mem[lst_ra];
    end
  end

  // candidate built from the registered reads
  logic [LenW-1:0]   prev_len;
  logic [GrpW+1:0]   ng;
  logic [LenW+1:0]   sum;
  logic [LenW-1:0]   dl;
  cand_t             cand;
  entry_t            list [MaxKeep];
  logic              ch_clear, ch_load;

  assign prev_len = (j_q == '0) ? '0 : len_rd_q;
  assign ng  = (j_q == '0) ? 9'd1 : 9'(grp_rd_q) + 9'd1;
  assign sum = (LenW+2)'(prev_len) + (LenW+2)'(seg_rd_q) + (LenW+2)'(ovh_q);
  assign dl  = (sum > (LenW+2)'(LenMax)) ? LenMax : sum[LenW-1:0];
  assign cand.vld   = (ng <= 9'(gall_q)) & ~(ben_q & (dl > bound_q));
  assign cand.len   = dl;
  assign cand.grp   = ng[GrpW-1:0];
  assign cand.start = j_q;
  assign cand.back  = RankW'(t_q - CntW'(1));

  kbsd_chain u_chain (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (ch_clear),
    .load_i  (ch_load),
    .keep_i  (keep),
    .cand_i  (cand),
    .list_o  (list)
  );

  logic [CntW-1:0] list_cnt;
  always_comb begin
    list_cnt = '0;
    for (int g = 0; g < MaxKeep; g++) begin
      if (list[g].vld) list_cnt = CntW'(g + 1);
    end
  end
  assign cp_ent = list[k_q[RankW-1:0]];

  // last copy cycle of a row
  logic copy_done;
  assign copy_done = (k_q + CntW'(1) >= CntW'(MaxKeep)) || (k_q + CntW'(1) >= list_cnt);

  always_ff @(posedge clk_i) begin
    if (cnt_we) cnt_mem[cnt_wa] <= list_cnt;
    if (cnt_re) cnt_rd_q <= cnt_vld_q[cnt_ra] ? cnt_mem[cnt_ra] : '0;
  end

  assign s_axis_tready = (st_q == StIdle);

  logic acc_in;
  assign acc_in = s_axis_tvalid & s_axis_tready;

  // combinational control
  always_comb begin
    seg_we = acc_in & (in_cmd == CmdLoad);
    seg_wa = {in_first, in_last};
    seg_re = (st_q == StSeg);
    seg_ra = {j_q, i_q};
    lst_we = (st_q == StCopy) & (k_q < list_cnt);
    lst_wa = {i_q, k_q[RankW-1:0]};
    cnt_we = (st_q == StCopy) & copy_done;
    cnt_wa = i_q;
    lst_re = 1'b0;
    lst_ra = '0;
    cnt_re = 1'b0;
    cnt_ra = '0;
    case (st_q)
      StIdle: begin
        // list length of the final prefix, checked by a trace
        cnt_re = 1'b1;
        cnt_ra = fin;
      end
      StSeg: begin
        lst_re = (j_q != '0);
        lst_ra = {j_q - BlkW'(1), RankW'(t_q - CntW'(1))};
        // prior count for the next start
        cnt_re = 1'b1;
        cnt_ra = j_q;
      end
      StEmitR: begin
        lst_re = 1'b1;
        lst_ra = {fin, k_q[RankW-1:0]};
      end
      StTrR: begin
        lst_re = 1'b1;
        lst_ra = {tj_q, tk_q};
      end
      StTr: begin
        // list length of the prefix the back pointer leads to
        cnt_re = 1'b1;
        cnt_ra = sta_rd_q - BlkW'(1);
      end
      default: ;
    endcase
    ch_clear = (st_q == StRow);
    ch_load  = (st_q == StIns);
  end

  logic out_free;
  assign out_free = ~out_vld_q | m_axis_tready;

  // a result enters the output register this cycle
  logic out_push;
  assign out_push = out_free & ((st_q == StEmit) | ((st_q == StOut) & (idx_q < tr_tot_q)));

  logic [GrpW-1:0] ngn;
  assign ngn = tr_tot_q - GrpW'(1) - idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      i_q <= '0; j_q <= '0; t_q <= '0; k_q <= '0;
      tj_q <= '0; tk_q <= '0; idx_q <= '0;
      tr_rank_q <= '0; tr_len_q <= '0; tr_tot_q <= '0;
      out_vld_q <= 1'b0; out_last_q <= 1'b0; out_data_q <= '0;
      cnt_vld_q <= '0;
    end else begin
      if (out_push) begin
        out_vld_q <= 1'b1;
      end else if (out_vld_q && m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      unique case (st_q)
        StIdle: begin
          if (acc_in) begin
            if (in_cmd == CmdSolve) begin
              i_q  <= '0;
              st_q <= StRow;
            end else if (in_cmd == CmdTrace) begin
              tr_rank_q <= in_rank;
              tj_q  <= fin;
              tk_q  <= in_rank;
              idx_q <= '0;
              st_q  <= StTrC;
            end
          end
        end
        StTrC: begin
          // rank beyond the final list emits nothing
          st_q <= (CntW'(tr_rank_q) < cnt_rd_q) ? StTrR : StIdle;
        end
        StRow: begin
          j_q  <= '0;
          t_q  <= CntW'(1);
          st_q <= StSeg;
        end
        StSeg: begin
          st_q <= (t_q == '0) ? StSkip : StRd;
        end
        StSkip: begin
          if (j_q == i_q) begin
            k_q  <= '0;
            st_q <= StCopy;
          end else begin
            j_q  <= j_q + BlkW'(1);
            t_q  <= cnt_rd_q;
            st_q <= StSeg;
          end
        end
        StRd: st_q <= StIns;
        StIns: begin
          if (t_q > CntW'(1)) begin
            t_q  <= t_q - CntW'(1);
            st_q <= StSeg;
          end else if (j_q == i_q) begin
            k_q  <= '0;
            st_q <= StCopy;
          end else begin
            j_q  <= j_q + BlkW'(1);
            t_q  <= cnt_rd_q;
            st_q <= StSeg;
          end
        end
        StCopy: begin
          if (copy_done) begin
            cnt_vld_q[i_q] <= 1'b1;
            if (i_q == fin) begin
              k_q  <= '0;
              st_q <= (list_cnt == '0) ? StIdle : StEmitR;
            end else begin
              i_q  <= i_q + BlkW'(1);
              st_q <= StRow;
            end
          end else begin
            k_q <= k_q + CntW'(1);
          end
        end
        StEmitR: st_q <= StEmit;
        StEmit: begin
          // the chain still holds the final list, so its count is the length
          if (out_free) begin
            out_data_q <= {1'd0, 6'd0, 6'd0, grp_rd_q, len_rd_q, k_q[RankW-1:0]};
            out_last_q <= (k_q + CntW'(1) == list_cnt);
            if (k_q + CntW'(1) == list_cnt) begin
              st_q <= StIdle;
            end else begin
              k_q  <= k_q + CntW'(1);
              st_q <= StEmitR;
            end
          end
        end
        StTrR: st_q <= StTr;
        StTr: begin
          if (idx_q == '0) begin
            tr_len_q <= len_rd_q;
            tr_tot_q <= grp_rd_q;
          end
          st_q <= StOut;
        end
        StOut: begin
          if (idx_q >= tr_tot_q) begin
            st_q <= StIdle;
          end else if (out_free) begin
            out_data_q <= {1'd0, ngn[BlkW-1:0], sta_rd_q, tr_tot_q, tr_len_q, tr_rank_q};
            idx_q      <= idx_q + GrpW'(1);
            if (ngn == '0 || sta_rd_q == '0 || idx_q + GrpW'(1) >= GrpW'(TraceLimit) ||
                CntW'(bck_rd_q) >= cnt_rd_q) begin
              out_last_q <= 1'b1;
              st_q       <= StIdle;
            end else begin
              out_last_q <= 1'b0;
              tj_q <= sta_rd_q - BlkW'(1);
              tk_q <= bck_rd_q;
              st_q <= StTrR;
            end
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule
